/* rtl/core/mhb_pkg.sv */
// mhb_pkg: shared constants, sequencer states and unit request/response types
// for the murmur64 string hash bucket block
// no dependencies
package mhb_pkg;

	localparam logic [63:0] MUR_M      = 64'hc6a4_a793_5bd1_e995;
	localparam int unsigned MUR_R      = 47;
	localparam logic [63:0] SEED_RESET = 64'h0000_00de_cafc_affe;
	localparam logic [62:0] BUCKET_RESET = 63'd1;

	typedef enum logic [0:0] {
		CFG_HASH_SEED,
		CFG_BUCKET_COUNT
	} mhb_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_MIX,
		ST_K1,
		ST_K2,
		ST_HM,
		ST_FX,
		ST_FM,
		ST_DIV,
		ST_OUT
	} mhb_state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] operand;
	} mhb_mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] product;
	} mhb_mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [62:0] divisor;
	} mhb_div_req_t;

	typedef struct packed {
		logic        done;
		logic [62:0] remainder;
	} mhb_div_rsp_t;

	// xor-shift step of the murmur finaliser
	function automatic logic [63:0] xorshift(input logic [63:0] v);
		xorshift = v ^ (v >> MUR_R);
	endfunction

endpackage

/* rtl/core/mhb_chunk_if.sv */
// mhb_chunk_if: input channel carrying one string chunk per beat
// valid/ready handshake; no dependencies
interface mhb_chunk_if;
	logic        valid;
	logic        ready;
	logic [63:0] chunk_bytes;
	logic [3:0]  valid_bytes;
	logic [31:0] string_length;
	logic        first_chunk;
	logic        last_chunk;

	modport source (
		output valid, chunk_bytes, valid_bytes, string_length, first_chunk, last_chunk,
		input  ready
	);
	modport sink (
		input  valid, chunk_bytes, valid_bytes, string_length, first_chunk, last_chunk,
		output ready
	);
endinterface

/* rtl/core/mhb_result_if.sv */
// mhb_result_if: output channel carrying one hash and bucket index per beat
// valid/ready handshake; no dependencies
interface mhb_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;
	logic [62:0] bucket_index;

	modport source (
		output valid, hash_value, bucket_index,
		input  ready
	);
	modport sink (
		input  valid, hash_value, bucket_index,
		output ready
	);
endinterface

/* rtl/core/mhb_mul.sv */
// mhb_mul: shared 64-bit multiply by the murmur constant, low 64 bits kept
// built from three 32x32 partial products on one multiplier; uses mhb_pkg
module mhb_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mhb_pkg::mhb_mul_req_t req,
	output mhb_pkg::mhb_mul_rsp_t rsp
);
	import mhb_pkg::*;

	localparam logic [31:0] M_LO = MUR_M[31:0];
	localparam logic [31:0] M_HI = MUR_M[63:32];

	logic        busy_q;
	logic [1:0]  cnt_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] op_a;
	logic [31:0] op_m;
	logic [63:0] prod_c;

	// step 0: lo*lo, step 1: a_lo*m_hi, step 2: a_hi*m_lo; hi*hi falls off the top
	assign op_a   = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign op_m   = (cnt_q == 2'd1) ? M_HI : M_LO;
	assign prod_c = op_a * op_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd3);
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q)
			a_q <= req.operand;
		if (busy_q) begin
			prod_q <= prod_c;
			case (cnt_q) inside
				2'd1:       acc_q <= prod_q;
				2'd2, 2'd3: acc_q <= acc_q + {prod_q[31:0], 32'b0};
				default: ;
			endcase
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

/* rtl/core/mhb_div.sv */
// mhb_div: restoring remainder unit, one quotient bit per cycle
// 64-bit dividend, 63-bit divisor; uses mhb_pkg
module mhb_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mhb_pkg::mhb_div_req_t req,
	output mhb_pkg::mhb_div_rsp_t rsp
);
	import mhb_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [62:0] dsr_q;
	logic [62:0] rem_q;
	logic [63:0] trial;
	logic [63:0] diff;
	logic        fits;

	// partial remainder stays below the divisor, so the shifted trial fits 64 bits
	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= fits ? diff[62:0] : trial[62:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

/* rtl/core/murmur64_string_hash_bucket.sv */
// murmur64_string_hash_bucket: MurmurHash64A over a chunked string, plus hash mod buckets
// sequencer around one shared multiplier (mhb_mul) and one remainder unit (mhb_div)
// uses mhb_pkg, mhb_chunk_if, mhb_result_if
//
// A string enters on the chunk channel as little-endian 64-bit beats. The first
// beat carries the total length, which seeds the hash with hash_seed. A beat of
// fewer than eight valid bytes always closes the string; so does last_chunk.
// Beats without first_chunk while no string is open are dropped. One result beat
// per string leaves on the result channel: the 64-bit hash and hash mod
// bucket_count (a count of zero acts as one).
// Chunk ready is high only while the sequencer is idle. Every multiply runs on the
// shared unit: a full 8-byte beat costs three multiplies, the opening beat one more
// for the seed, and closing a string adds one multiply, the remainder step and the
// output step.
// The result sits in an output register; while the receiver stalls a finished string
// waits there and the next string may be taken in and hashed until it too is ready to
// leave. hash_seed and bucket_count are written on the cfg port while idle; that is a
// rule for the user, which the block itself does not enforce. Reset clears the sequencer,
// closes any open string and restores hash_seed to 0xdecafcaffe and bucket_count to one.
module murmur64_string_hash_bucket (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  mhb_pkg::mhb_cfg_idx_t cfg_index,
	input  logic [63:0]          cfg_wr_data,
	mhb_chunk_if.sink            chunk,
	mhb_result_if.source         result
);
	import mhb_pkg::*;

	mhb_state_t   state_q;
	mhb_state_t   state_d;
	mhb_mul_req_t mul_req;
	mhb_mul_rsp_t mul_rsp;
	mhb_div_req_t div_req;
	mhb_div_rsp_t div_rsp;

	logic [63:0] seed_q;
	logic [62:0] bucket_q;
	logic        open_q;
	logic        launched_q;
	logic        accept;

	logic [63:0] chunk_q;
	logic [3:0]  nv_q;
	logic [31:0] len_q;
	logic        final_q;
	logic [63:0] h_q;
	logic [63:0] k_q;
	logic [63:0] tail_mask;

	logic        res_valid_q;
	logic [63:0] res_hash_q;
	logic [62:0] res_bucket_q;
	logic        res_load;

	assign accept      = chunk.valid && chunk.ready;
	assign chunk.ready = (state_q == ST_IDLE);
	assign res_load    = (state_q == ST_OUT) && (!res_valid_q || result.ready);
	assign tail_mask   = ~({64{1'b1}} << {nv_q[2:0], 3'b000});

	mhb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mhb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SEED_RESET;
			bucket_q <= BUCKET_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_HASH_SEED:    seed_q   <= cfg_wr_data;
				CFG_BUCKET_COUNT: bucket_q <= cfg_wr_data[62:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		mul_req.start    = 1'b0;
		mul_req.operand  = h_q;
		div_req.start    = 1'b0;
		div_req.dividend = h_q;
		div_req.divisor  = (bucket_q == '0) ? 63'd1 : bucket_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (chunk.first_chunk)
						state_d = ST_SEED;
					else if (open_q)
						state_d = ST_MIX;
				end
			end
			ST_SEED: begin
				mul_req.start   = !launched_q;
				mul_req.operand = {32'b0, len_q};
				if (mul_rsp.done)
					state_d = ST_MIX;
			end
			ST_MIX: begin
				if (nv_q[3])
					state_d = ST_K1;
				else if (nv_q != '0)
					state_d = ST_HM;
				else
					state_d = ST_FX;
			end
			ST_K1: begin
				mul_req.start   = !launched_q;
				mul_req.operand = chunk_q;
				if (mul_rsp.done)
					state_d = ST_K2;
			end
			ST_K2: begin
				mul_req.start   = !launched_q;
				mul_req.operand = k_q;
				if (mul_rsp.done)
					state_d = ST_HM;
			end
			ST_HM: begin
				mul_req.start = !launched_q;
				if (mul_rsp.done)
					state_d = final_q ? ST_FM : ST_IDLE;
			end
			ST_FX: begin
				state_d = ST_FM;
			end
			ST_FM: begin
				mul_req.start = !launched_q;
				if (mul_rsp.done)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				div_req.start = !launched_q;
				if (div_rsp.done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (res_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// one unit job in flight per sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launched_q <= 1'b0;
			open_q     <= 1'b0;
		end else begin
			if (mul_rsp.done || div_rsp.done)
				launched_q <= 1'b0;
			else if (mul_req.start || div_req.start)
				launched_q <= 1'b1;
			if (accept && chunk.first_chunk)
				open_q <= 1'b1;
			else if (res_load)
				open_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chunk_q <= chunk.chunk_bytes;
			// counts above eight act as a full chunk
			nv_q    <= chunk.valid_bytes[3] ? 4'd8 : chunk.valid_bytes;
			len_q   <= chunk.string_length;
			final_q <= chunk.last_chunk || !chunk.valid_bytes[3];
		end
		unique case (state_q)
			ST_SEED: if (mul_rsp.done) h_q <= seed_q ^ mul_rsp.product;
			ST_MIX:  if (!nv_q[3]) h_q <= h_q ^ (chunk_q & tail_mask);
			ST_K1:   if (mul_rsp.done) k_q <= xorshift(mul_rsp.product);
			ST_K2:   if (mul_rsp.done) h_q <= h_q ^ mul_rsp.product;
			ST_HM: begin
				if (mul_rsp.done)
					h_q <= final_q ? xorshift(mul_rsp.product) : mul_rsp.product;
			end
			ST_FX:   h_q <= xorshift(h_q);
			ST_FM:   if (mul_rsp.done) h_q <= xorshift(mul_rsp.product);
			default: ;
		endcase
		if (res_load) begin
			res_hash_q   <= h_q;
			res_bucket_q <= div_rsp.remainder;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.hash_value   = res_hash_q;
	assign result.bucket_index = res_bucket_q;

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_OUT))
		else $error("result beat raised outside the output step");

	a_mul_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_SEED || state_q == ST_K1 || state_q == ST_K2
			|| state_q == ST_HM || state_q == ST_FM))
		else $error("multiplier finished with no step waiting on it");

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("remainder unit finished outside the remainder step");

	a_closed_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> !open_q && (state_q == ST_IDLE))
		else $error("string still open after its result was loaded");

endmodule
